// ===== rtl/skvt_pkg.sv =====
package skvt_pkg;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_FIND   = 3'd2;
    localparam logic [2:0] CMD_READ   = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DUP      = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] key;
        logic signed [31:0] info;
        logic [7:0]         position;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] found_key;
        logic signed [31:0] found_info;
        logic [5:0]         entry_count;
    } res_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] info;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_CHK,
        S_POS_CHK,
        S_SHL,
        S_SHL_WR,
        S_SHR,
        S_SHR_WR,
        S_DONE
    } seq_state_t;

endpackage

// ===== rtl/skvt_mem.sv =====
module skvt_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  skvt_pkg::entry_t     wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output skvt_pkg::entry_t     rd_data
);

    skvt_pkg::entry_t mem [DEPTH];
    skvt_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/skvt_cmp.sv =====
module skvt_cmp (
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        less,
    output logic        equal
);

    assign less  = $signed(a) < $signed(b);
    assign equal = (a == b);

endmodule

// ===== rtl/skvt_seq.sv =====
module skvt_seq #(
    parameter int CAPACITY = 32,
    parameter int AW       = 5,
    parameter int CW       = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  skvt_pkg::req_t       req,
    output logic                 done,
    output skvt_pkg::res_t       result,
    input  logic                 take,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output skvt_pkg::entry_t     wr_data,
    output logic                 rd_en,
    output logic [AW-1:0]        rd_addr,
    input  skvt_pkg::entry_t     rd_data,
    input  logic                 key_less,
    input  logic                 key_equal
);

    localparam int PW = CW + 8;

    skvt_pkg::seq_state_t state_reg, state_next;
    logic [CW-1:0]        fill_reg, fill_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        ptr_reg, ptr_next;
    logic [2:0]           cmd_reg, cmd_next;
    logic [31:0]          key_reg, key_next;
    logic [31:0]          info_reg, info_next;
    logic [1:0]           status_reg, status_next;
    logic [31:0]          rkey_reg, rkey_next;
    logic [31:0]          rinfo_reg, rinfo_next;

    logic [7:0]           pos_eff;
    logic [7:0]           pos_idx;
    logic [CW-1:0]        ptr_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skvt_pkg::S_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        ptr_reg    <= ptr_next;
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        info_reg   <= info_next;
        status_reg <= status_next;
        rkey_reg   <= rkey_next;
        rinfo_reg  <= rinfo_next;
    end

    assign pos_eff = (req.position == 8'd0) ? 8'd1 : req.position;
    assign pos_idx = pos_eff - 8'd1;
    assign ptr_inc = ptr_reg + CW'(1);

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        ptr_next    = ptr_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        info_next   = info_reg;
        status_next = status_reg;
        rkey_next   = rkey_reg;
        rinfo_next  = rinfo_reg;
        req_ready   = 1'b0;
        done        = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = ptr_reg[AW-1:0];
        wr_data     = rd_data;
        rd_en       = 1'b0;
        rd_addr     = ptr_reg[AW-1:0];

        case (state_reg)
            skvt_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd_next    = req.cmd;
                    key_next    = req.key;
                    info_next   = req.info;
                    idx_next    = '0;
                    status_next = skvt_pkg::ST_OK;
                    rkey_next   = '0;
                    rinfo_next  = '0;
                    case (req.cmd)
                        skvt_pkg::CMD_INSERT,
                        skvt_pkg::CMD_REMOVE,
                        skvt_pkg::CMD_FIND:
                        begin
                            state_next = skvt_pkg::S_SCAN;
                        end
                        skvt_pkg::CMD_READ:
                        begin
                            if (PW'(pos_eff) <= PW'(fill_reg))
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(pos_idx);
                                state_next = skvt_pkg::S_POS_CHK;
                            end
                            else
                            begin
                                status_next = skvt_pkg::ST_NOTFOUND;
                                state_next  = skvt_pkg::S_DONE;
                            end
                        end
                        skvt_pkg::CMD_CLEAR:
                        begin
                            fill_next  = '0;
                            state_next = skvt_pkg::S_DONE;
                        end
                        default:
                        begin
                            state_next = skvt_pkg::S_DONE;
                        end
                    endcase
                end
            end

            skvt_pkg::S_POS_CHK:
            begin
                rkey_next  = rd_data.key;
                rinfo_next = rd_data.info;
                state_next = skvt_pkg::S_DONE;
            end

            skvt_pkg::S_SCAN:
            begin
                if (idx_reg < fill_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg[AW-1:0];
                    state_next = skvt_pkg::S_SCAN_CHK;
                end
                else if (cmd_reg == skvt_pkg::CMD_INSERT)
                begin
                    // The new key is above every stored key: append.
                    if (fill_reg >= CW'(CAPACITY))
                    begin
                        status_next = skvt_pkg::ST_FULL;
                        state_next  = skvt_pkg::S_DONE;
                    end
                    else
                    begin
                        ptr_next   = fill_reg;
                        state_next = skvt_pkg::S_SHR;
                    end
                end
                else
                begin
                    status_next = skvt_pkg::ST_NOTFOUND;
                    state_next  = skvt_pkg::S_DONE;
                end
            end

            skvt_pkg::S_SCAN_CHK:
            begin
                if (key_less)
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = skvt_pkg::S_SCAN;
                end
                else if (key_equal)
                begin
                    if (cmd_reg == skvt_pkg::CMD_INSERT)
                    begin
                        status_next = skvt_pkg::ST_DUP;
                    end
                    rkey_next  = rd_data.key;
                    rinfo_next = rd_data.info;
                    if (cmd_reg == skvt_pkg::CMD_REMOVE)
                    begin
                        ptr_next   = idx_reg;
                        state_next = skvt_pkg::S_SHL;
                    end
                    else
                    begin
                        state_next = skvt_pkg::S_DONE;
                    end
                end
                else if (cmd_reg == skvt_pkg::CMD_INSERT)
                begin
                    if (fill_reg >= CW'(CAPACITY))
                    begin
                        status_next = skvt_pkg::ST_FULL;
                        state_next  = skvt_pkg::S_DONE;
                    end
                    else
                    begin
                        ptr_next   = fill_reg;
                        state_next = skvt_pkg::S_SHR;
                    end
                end
                else
                begin
                    status_next = skvt_pkg::ST_NOTFOUND;
                    state_next  = skvt_pkg::S_DONE;
                end
            end

            // Close the gap left by a removed entry, one entry per pass.
            skvt_pkg::S_SHL:
            begin
                if (ptr_inc < fill_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_inc[AW-1:0];
                    state_next = skvt_pkg::S_SHL_WR;
                end
                else
                begin
                    fill_next  = fill_reg - CW'(1);
                    state_next = skvt_pkg::S_DONE;
                end
            end

            skvt_pkg::S_SHL_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = ptr_reg[AW-1:0];
                wr_data    = rd_data;
                ptr_next   = ptr_inc;
                state_next = skvt_pkg::S_SHL;
            end

            // Open a slot at the insertion point, moving entries up from the top.
            skvt_pkg::S_SHR:
            begin
                if (ptr_reg > idx_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(ptr_reg - CW'(1));
                    state_next = skvt_pkg::S_SHR_WR;
                end
                else
                begin
                    wr_en        = 1'b1;
                    wr_addr      = idx_reg[AW-1:0];
                    wr_data.key  = key_reg;
                    wr_data.info = info_reg;
                    fill_next    = fill_reg + CW'(1);
                    state_next   = skvt_pkg::S_DONE;
                end
            end

            skvt_pkg::S_SHR_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = ptr_reg[AW-1:0];
                wr_data    = rd_data;
                ptr_next   = ptr_reg - CW'(1);
                state_next = skvt_pkg::S_SHR;
            end

            skvt_pkg::S_DONE:
            begin
                done = 1'b1;
                if (take)
                begin
                    state_next = skvt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = skvt_pkg::S_IDLE;
            end
        endcase
    end

    assign result.status      = status_reg;
    assign result.found_key   = rkey_reg;
    assign result.found_info  = rinfo_reg;
    assign result.entry_count = 6'(fill_reg);

endmodule

// ===== rtl/sorted_key_value_table_top.sv =====
// Sorted key/info table holding up to CAPACITY pairs in ascending signed key
// order in a single-port-write, registered-read memory. Each request is one
// of insert, remove by key, find by key, read at a 1-based position, or clear,
// and yields exactly one response with status, key, info and entry count;
// other command codes change nothing and are answered with status OK.
// Requests are handled one at a time by a small sequencer that walks the
// memory through one shared key comparator: a key lookup reads, then
// compares, each entry scanned, and an insert or remove moves entries one
// by one to open or close a slot. A finished response waits in an output
// register, so the next request is taken while it is still pending.
module sorted_key_value_table_top #(
    parameter int CAPACITY = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  skvt_pkg::req_t   req,
    output logic             res_valid,
    input  logic             res_ready,
    output skvt_pkg::res_t   res
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic             seq_done;
    logic             seq_take;
    skvt_pkg::res_t   seq_result;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    skvt_pkg::entry_t wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    skvt_pkg::entry_t rd_data;
    logic             key_less;
    logic             key_equal;
    logic [31:0]      seq_key_b;
    logic [31:0]      key_hold_reg;

    logic             res_valid_reg, res_valid_next;
    skvt_pkg::res_t   res_reg;

    skvt_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    skvt_cmp u_cmp (
        .a     (rd_data.key),
        .b     (seq_key_b),
        .less  (key_less),
        .equal (key_equal)
    );

    assign seq_key_b = key_hold_reg;

    // The comparator's second operand is the request key, held for the scan.
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            key_hold_reg <= req.key;
        end
    end

    skvt_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .done      (seq_done),
        .result    (seq_result),
        .take      (seq_take),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .key_less  (key_less),
        .key_equal (key_equal)
    );

    assign seq_take = seq_done && (!res_valid_reg || res_ready);

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (seq_take)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_take)
        begin
            res_reg <= seq_result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== tb/sv/table_response_checker.sv =====
`timescale 1ns / 100ps

module table_response_checker #(
    parameter int CAPACITY = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_ready,
    input  skvt_pkg::req_t req,
    input  logic           res_valid,
    input  logic           res_ready,
    input  skvt_pkg::res_t res,
    output int             fail_count,
    output int             outstanding
);

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the table, kept sorted by signed key.
    logic signed [31:0] shadow_key  [CAPACITY];
    logic signed [31:0] shadow_info [CAPACITY];
    int                 shadow_fill;

    skvt_pkg::res_t expected_responses[$];
    int             response_index;

    function automatic skvt_pkg::res_t apply_command(input skvt_pkg::req_t r);
        skvt_pkg::res_t rsp;
        int             slot;
        int             rank;
        bit             hit;
        rsp = '0;
        rsp.status = skvt_pkg::ST_OK;
        slot = 0;
        while (slot < shadow_fill && shadow_key[slot] < r.key)
            slot++;
        hit = (slot < shadow_fill) && (shadow_key[slot] == r.key);
        case (r.cmd)
            skvt_pkg::CMD_INSERT:
            begin
                // A duplicate wins over a full table.
                if (hit)
                begin
                    rsp.status = skvt_pkg::ST_DUP;
                    rsp.found_key = shadow_key[slot];
                    rsp.found_info = shadow_info[slot];
                end
                else if (shadow_fill >= CAPACITY)
                    rsp.status = skvt_pkg::ST_FULL;
                else
                begin
                    for (int j = shadow_fill; j > slot; j--)
                    begin
                        shadow_key[j] = shadow_key[j - 1];
                        shadow_info[j] = shadow_info[j - 1];
                    end
                    shadow_key[slot] = r.key;
                    shadow_info[slot] = r.info;
                    shadow_fill++;
                end
            end
            skvt_pkg::CMD_REMOVE:
            begin
                if (hit)
                begin
                    rsp.found_key = shadow_key[slot];
                    rsp.found_info = shadow_info[slot];
                    for (int j = slot; j + 1 < shadow_fill; j++)
                    begin
                        shadow_key[j] = shadow_key[j + 1];
                        shadow_info[j] = shadow_info[j + 1];
                    end
                    shadow_fill--;
                end
                else
                    rsp.status = skvt_pkg::ST_NOTFOUND;
            end
            skvt_pkg::CMD_FIND:
            begin
                if (hit)
                begin
                    rsp.found_key = shadow_key[slot];
                    rsp.found_info = shadow_info[slot];
                end
                else
                    rsp.status = skvt_pkg::ST_NOTFOUND;
            end
            skvt_pkg::CMD_READ:
            begin
                rank = (r.position == 0) ? 1 : int'(r.position);
                if (rank <= shadow_fill)
                begin
                    rsp.found_key = shadow_key[rank - 1];
                    rsp.found_info = shadow_info[rank - 1];
                end
                else
                    rsp.status = skvt_pkg::ST_NOTFOUND;
            end
            skvt_pkg::CMD_CLEAR:
                shadow_fill = 0;
            default:
                ;
        endcase
        rsp.entry_count = shadow_fill[5:0];
        return rsp;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        skvt_pkg::res_t want;
        if (!rst_n)
        begin
            shadow_fill = 0;
            expected_responses.delete();
            response_index = 0;
            fail_count = 0;
            outstanding = 0;
        end
        else
        begin
            // Requests are logged first, so a response is always matched
            // against the oldest request still open.
            if (req_valid && req_ready)
                expected_responses.push_back(apply_command(req));
            if (res_valid && res_ready)
            begin
                if (expected_responses.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("response %0d with no request open: %s %0d %0d %0d %0d",
                                 response_index, "status/key/info/count", res.status,
                                 res.found_key, res.found_info, res.entry_count);
                end
                else
                begin
                    want = expected_responses.pop_front();
                    if (res.status !== want.status || res.found_key !== want.found_key ||
                        res.found_info !== want.found_info ||
                        res.entry_count !== want.entry_count)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $display("response %0d: expected status %0d key %0d info %0d count %0d",
                                     response_index, want.status, want.found_key,
                                     want.found_info, want.entry_count);
                            $display("    got status %0d key %0d info %0d count %0d",
                                     res.status, res.found_key, res.found_info,
                                     res.entry_count);
                        end
                    end
                end
                response_index++;
            end
            outstanding = expected_responses.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int CAPACITY = 32;
    localparam int POOL_SIZE = 48;
    localparam int SEGMENT_LEN = 50;
    localparam int NUM_SEGMENTS = 30;
    localparam int QUIET_SEGMENTS = 3;
    localparam int DRAIN_CYCLES = 150;
    localparam int WATCHDOG_LIMIT = 4000;

    // Codes the block must ignore.
    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

    typedef enum int {LOAD_FILL, LOAD_DRAIN, LOAD_BALANCED} load_mode_t;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    skvt_pkg::req_t req;
    logic           res_valid;
    logic           res_ready;
    skvt_pkg::res_t res;

    int fail_count;
    int outstanding;
    int req_idle_odds;
    int res_stall_odds;
    int idle_cycles;

    logic signed [31:0] key_pool [POOL_SIZE];

    sorted_key_value_table_top #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    table_response_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sorted_key_value_table_top: mismatch");
            $finish;
        end
    end

    // Response side back-pressure in bursts of random length.
    initial
    begin
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (res_stall_odds != 0 && $urandom_range(1, res_stall_odds) == 1)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge clk);
            end
            else
                res_ready <= 1'b1;
        end
    end

    task automatic issue(input logic [2:0] op, input logic signed [31:0] k,
                         input logic signed [31:0] v, input logic [7:0] pos);
        skvt_pkg::req_t item;
        item.cmd = op;
        item.key = k;
        item.info = v;
        item.position = pos;
        @(negedge clk);
        if (req_idle_odds != 0 && $urandom_range(1, req_idle_odds) == 1)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    initial
    begin
        load_mode_t         mode;
        int                 pick;
        int                 insert_cut;
        int                 remove_cut;
        logic [2:0]         op;
        logic signed [31:0] k;
        logic [7:0]         pos;

        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        req_idle_odds = 0;
        res_stall_odds = 0;

        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = 32'sd0;
        key_pool[3] = -32'sd1;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, extreme keys, ranks, duplicates, ignored codes.
        issue(skvt_pkg::CMD_READ, 0, 0, 8'd0);
        issue(skvt_pkg::CMD_FIND, 32'sd5, 0, 8'd1);
        issue(skvt_pkg::CMD_REMOVE, 32'sd5, 0, 8'd1);
        issue(skvt_pkg::CMD_INSERT, KEY_MIN, KEY_MAX, 8'd0);
        issue(skvt_pkg::CMD_INSERT, KEY_MAX, KEY_MIN, 8'd0);
        issue(skvt_pkg::CMD_INSERT, 32'sd0, -32'sd1, 8'd0);
        issue(skvt_pkg::CMD_INSERT, 32'sd0, 32'sd77, 8'd0);
        issue(skvt_pkg::CMD_FIND, KEY_MAX, 0, 8'd0);
        issue(skvt_pkg::CMD_FIND, KEY_MIN, 0, 8'd0);
        issue(skvt_pkg::CMD_READ, 0, 0, 8'd0);
        issue(skvt_pkg::CMD_READ, 0, 0, 8'd3);
        issue(skvt_pkg::CMD_READ, 0, 0, 8'd4);
        issue(skvt_pkg::CMD_READ, 0, 0, 8'd255);
        issue(skvt_pkg::CMD_REMOVE, 32'sd0, 0, 8'd0);
        issue(skvt_pkg::CMD_REMOVE, 32'sd0, 0, 8'd0);
        for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
            issue(3'(c), KEY_MIN, KEY_MAX, 8'hff);
        issue(skvt_pkg::CMD_READ, 0, 0, 8'd2);
        issue(skvt_pkg::CMD_CLEAR, KEY_MAX, 0, 8'd0);
        issue(skvt_pkg::CMD_READ, 0, 0, 8'd1);
        issue(skvt_pkg::CMD_FIND, KEY_MIN, 0, 8'd0);

        for (int seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            if (seg >= NUM_SEGMENTS - QUIET_SEGMENTS)
            begin
                mode = LOAD_BALANCED;
                req_idle_odds = 0;
                res_stall_odds = 0;
            end
            else
            begin
                mode = load_mode_t'($urandom_range(0, 2));
                case ($urandom_range(0, 2))
                    0: req_idle_odds = 0;
                    1: req_idle_odds = 4;
                    default: req_idle_odds = 12;
                endcase
                case ($urandom_range(0, 2))
                    0: res_stall_odds = 0;
                    1: res_stall_odds = 4;
                    default: res_stall_odds = 12;
                endcase
            end
            case (mode)
                LOAD_FILL:
                begin
                    insert_cut = 60;
                    remove_cut = 70;
                end
                LOAD_DRAIN:
                begin
                    insert_cut = 10;
                    remove_cut = 60;
                end
                default:
                begin
                    insert_cut = 35;
                    remove_cut = 60;
                end
            endcase
            for (int n = 0; n < SEGMENT_LEN; n++)
            begin
                // Keys mostly come from a small pool so hits and duplicates are common.
                k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                 : $urandom;
                pos = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 34))
                                                 : 8'($urandom_range(0, 255));
                pick = $urandom_range(0, 99);
                if (pick < insert_cut)
                    op = skvt_pkg::CMD_INSERT;
                else if (pick < remove_cut)
                    op = skvt_pkg::CMD_REMOVE;
                else if (pick < 80)
                    op = skvt_pkg::CMD_FIND;
                else if (pick < 96)
                    op = skvt_pkg::CMD_READ;
                else if (pick < 98)
                    op = (mode == LOAD_FILL) ? skvt_pkg::CMD_READ : skvt_pkg::CMD_CLEAR;
                else
                    op = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
                issue(op, k, $urandom, pos);
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("sorted_key_value_table_top: match");
        else
            $display("sorted_key_value_table_top: mismatch");
        $finish;
    end

endmodule
